FILE: hdl/taq_pkg.sv
// taq_pkg: shared constants, types and the arctangent table for the
// thrust attitude quaternion block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package taq_pkg;

    // CORDIC iteration count (8..32) and derived counter width
    localparam int CORDIC_ITERS = 16;
    localparam int ITER_W       = (CORDIC_ITERS > 1) ? $clog2(CORDIC_ITERS) : 1;

    // datapath widths
    localparam int DW    = 52;  // CORDIC x/y, holds prescaled vectors with gain
    localparam int AW    = 36;  // Q30 angles, including the pi pre-turn
    localparam int TW    = 32;  // Q30 sin/cos and their products
    localparam int MW_A  = 35;  // multiplier operand A
    localparam int STEP_W = 4;  // multiply sequence step counter

    // Q30 angle constants and CORDIC start value
    localparam logic signed [AW-1:0] ANG_PI      = 36'sd3373259426;
    localparam logic signed [AW-1:0] ANG_HALF_PI = 36'sd1686629713;
    localparam logic signed [TW-1:0] INV_GAIN    = 32'sd652032874;

    // Q1.14 saturation bound
    localparam logic signed [33:0] Q_ONE = 34'sd16384;

    // gravity register reset, 9.81 in Q16.16
    localparam logic [23:0] GRAVITY_RST = 24'd642908;

    // last step of each multiply sequence
    localparam logic [STEP_W-1:0] ROT_MUL_LAST  = 4'd4;
    localparam logic [STEP_W-1:0] HYP_MUL_LAST  = 4'd1;
    localparam logic [STEP_W-1:0] QUAT_MUL_LAST = 4'd12;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_YAW_GO,
        S_YAW_RUN,
        S_ROT_MUL,
        S_ROLL_GO,
        S_ROLL_RUN,
        S_HYP_MUL,
        S_PITCH_GO,
        S_PITCH_RUN,
        S_HR_GO,
        S_HR_RUN,
        S_HP_GO,
        S_HP_RUN,
        S_HY_GO,
        S_HY_RUN,
        S_QUAT_MUL,
        S_DONE
    } t_state;

    // CORDIC engine control and status
    typedef struct packed {
        logic start;
        logic vec;      // 1: vectoring, 0: rotation
    } t_cor_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_cor_stat;

    // atan(2^-i) in Q30, truncated, except entries 27..30, which are rounded
    function automatic logic [31:0] atan_tab(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h3243F6A8;
            5'd1:    v = 32'h1DAC6705;
            5'd2:    v = 32'h0FADBAFC;
            5'd3:    v = 32'h07F56EA6;
            5'd4:    v = 32'h03FEAB76;
            5'd5:    v = 32'h01FFD55B;
            5'd6:    v = 32'h00FFFAAA;
            5'd7:    v = 32'h007FFF55;
            5'd8:    v = 32'h003FFFEA;
            5'd9:    v = 32'h001FFFFD;
            5'd10:   v = 32'h000FFFFF;
            5'd11:   v = 32'h0007FFFF;
            5'd12:   v = 32'h0003FFFF;
            5'd13:   v = 32'h0001FFFF;
            5'd14:   v = 32'h0000FFFF;
            5'd15:   v = 32'h00007FFF;
            5'd16:   v = 32'h00003FFF;
            5'd17:   v = 32'h00001FFF;
            5'd18:   v = 32'h00000FFF;
            5'd19:   v = 32'h000007FF;
            5'd20:   v = 32'h000003FF;
            5'd21:   v = 32'h000001FF;
            5'd22:   v = 32'h000000FF;
            5'd23:   v = 32'h0000007F;
            5'd24:   v = 32'h0000003F;
            5'd25:   v = 32'h0000001F;
            5'd26:   v = 32'h0000000F;
            5'd27:   v = 32'h00000008;
            5'd28:   v = 32'h00000004;
            5'd29:   v = 32'h00000002;
            5'd30:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/taq_cordic.sv
// taq_cordic: iterative CORDIC engine, one micro-rotation per cycle,
// rotation mode (sin/cos) and vectoring mode (atan2/magnitude). Uses taq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module taq_cordic
    import taq_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cor_ctrl             i_ctrl,
    input  wire logic signed [DW-1:0]  i_x,
    input  wire logic signed [DW-1:0]  i_y,
    input  wire logic signed [AW-1:0]  i_z,
    output t_cor_stat                  o_stat,
    output logic signed [DW-1:0]       o_x,
    output logic signed [DW-1:0]       o_y,
    output logic signed [AW-1:0]       o_z
);

    logic                 r_busy;
    logic                 r_done;
    logic [ITER_W-1:0]    r_iter;
    logic                 r_vec;
    logic                 r_flip;
    logic                 r_zero;
    logic signed [DW-1:0] r_x;
    logic signed [DW-1:0] r_y;
    logic signed [AW-1:0] r_z;

    logic signed [DW-1:0] n_x;
    logic signed [DW-1:0] n_y;
    logic signed [AW-1:0] n_z;

    logic signed [DW-1:0] ld_x;
    logic signed [DW-1:0] ld_y;
    logic signed [AW-1:0] ld_z;
    logic                 ld_flip;
    logic                 ld_zero;

    logic signed [DW-1:0] x_sh;
    logic signed [DW-1:0] y_sh;
    logic signed [AW-1:0] atan_v;
    logic                 ccw;
    logic                 load;
    logic                 last;

    assign load = i_ctrl.start && !r_busy;
    assign last = (r_iter == ITER_W'(CORDIC_ITERS - 1));

    // start values: pi pre-turn for vectoring, half-plane fold for rotation
    always_comb begin
        ld_x    = i_x;
        ld_y    = i_y;
        ld_z    = '0;
        ld_flip = 1'b0;
        ld_zero = 1'b0;
        if (i_ctrl.vec) begin
            ld_zero = (i_x == '0) && (i_y == '0);
            if (i_x[DW-1]) begin
                ld_x = -i_x;
                ld_y = -i_y;
                ld_z = i_y[DW-1] ? -ANG_PI : ANG_PI;
            end
        end else begin
            ld_x = DW'(INV_GAIN);
            ld_y = '0;
            if (i_z > ANG_HALF_PI) begin
                ld_z    = i_z - ANG_PI;
                ld_flip = 1'b1;
            end else if (i_z < -ANG_HALF_PI) begin
                ld_z    = i_z + ANG_PI;
                ld_flip = 1'b1;
            end else begin
                ld_z = i_z;
            end
        end
    end

    // shared micro-rotation: shifts, add/sub, table lookup
    assign x_sh   = r_x >>> r_iter;
    assign y_sh   = r_y >>> r_iter;
    assign atan_v = AW'(atan_tab(5'(r_iter)));
    assign ccw    = r_vec ? r_y[DW-1] : ~r_z[AW-1];

    always_comb begin
        if (ccw) begin
            n_x = r_x - y_sh;
            n_y = r_y + x_sh;
            n_z = r_z - atan_v;
        end else begin
            n_x = r_x + y_sh;
            n_y = r_y - x_sh;
            n_z = r_z + atan_v;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (load) begin
                r_busy <= 1'b1;
            end else if (r_busy && last) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_x    <= ld_x;
            r_y    <= ld_y;
            r_z    <= ld_z;
            r_iter <= '0;
            r_vec  <= i_ctrl.vec;
            r_flip <= ld_flip;
            r_zero <= ld_zero;
        end else if (r_busy) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_iter <= r_iter + 1'b1;
        end
    end

    // results: sign undo of the fold, zero vector forced to zero
    assign o_x    = r_zero ? '0 : (r_flip ? -r_x : r_x);
    assign o_y    = r_flip ? -r_y : r_y;
    assign o_z    = r_zero ? '0 : r_z;
    assign o_stat = {r_busy, r_done};

endmodule

`default_nettype wire

FILE: hdl/thrust_attitude_quaternion_top.sv
// thrust_attitude_quaternion_top: thrust direction to ZYX attitude quaternion.
// The result strobe follows an accept after six passes through the one CORDIC engine
// and the rotate, hypot and quaternion multiply sequences of one shared multiplier.
// A new transaction is accepted only while busy is low; busy stays high through the strobe.
// Results are shown one cycle on o_strobe; the receiver cannot stall.
// Synchronous active-low reset: idle, gravity register back to 9.81. Uses taq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module thrust_attitude_quaternion_top
    import taq_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_cfg_we,
    input  wire logic [23:0]        i_cfg_wdata,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [31:0] i_pos_z,
    input  wire logic signed [15:0] i_yaw_angle,
    input  wire logic signed [31:0] i_accel_x,
    input  wire logic signed [31:0] i_accel_y,
    input  wire logic signed [31:0] i_accel_z,
    output logic                    o_strobe,
    output logic signed [31:0]      o_out_x,
    output logic signed [31:0]      o_out_y,
    output logic signed [31:0]      o_out_z,
    output logic signed [15:0]      o_quat_w,
    output logic signed [15:0]      o_quat_x,
    output logic signed [15:0]      o_quat_y,
    output logic signed [15:0]      o_quat_z
);

    // Q30 sum to Q1.14 with rounding and saturation
    function automatic logic signed [15:0] to_q14(input logic signed [33:0] v);
        logic signed [33:0] r;
        logic signed [15:0] q;
        r = (v + 34'sd32768) >>> 16;
        if (r > Q_ONE) begin
            q = 16'(Q_ONE);
        end else if (r < -Q_ONE) begin
            q = 16'(-Q_ONE);
        end else begin
            q = 16'(r);
        end
        return q;
    endfunction

    t_state              r_state;
    t_state              n_state;
    logic [STEP_W-1:0]   r_step;
    logic [23:0]         r_gravity;

    // transaction payload
    logic signed [31:0]  r_pos_x;
    logic signed [31:0]  r_pos_y;
    logic signed [31:0]  r_pos_z;
    logic signed [15:0]  r_yaw;
    logic signed [31:0]  r_tx;
    logic signed [31:0]  r_ty;
    logic signed [32:0]  r_tz;

    // intermediates
    logic signed [TW-1:0] r_cos;     // yaw, later half-yaw
    logic signed [TW-1:0] r_sin;
    logic signed [32:0]   r_rx;
    logic signed [32:0]   r_ry;
    logic signed [AW-1:0] r_roll;
    logic signed [AW-1:0] r_pitch;
    logic signed [DW-1:0] r_vmag;    // roll magnitude, then hypot operand
    logic signed [TW-1:0] r_cr;
    logic signed [TW-1:0] r_sr;
    logic signed [TW-1:0] r_cp;
    logic signed [TW-1:0] r_sp;
    logic signed [TW-1:0] r_crcp;
    logic signed [TW-1:0] r_srsp;
    logic signed [TW-1:0] r_crsp;
    logic signed [TW-1:0] r_srcp;
    logic signed [63:0]   r_prod;
    logic signed [63:0]   r_acc;
    logic signed [15:0]   r_qw;
    logic signed [15:0]   r_qx;
    logic signed [15:0]   r_qy;
    logic signed [15:0]   r_qz;

    // CORDIC engine hookup
    t_cor_ctrl            cor_ctrl;
    t_cor_stat            cor_stat;
    logic signed [DW-1:0] cor_x_in;
    logic signed [DW-1:0] cor_y_in;
    logic signed [AW-1:0] cor_z_in;
    logic signed [DW-1:0] cor_x;
    logic signed [DW-1:0] cor_y;
    logic signed [AW-1:0] cor_z;

    // shared multiplier
    logic signed [MW_A-1:0]    mul_a;
    logic signed [TW-1:0]      mul_b;
    logic signed [MW_A+TW-1:0] mul_p;

    logic signed [63:0]   acc_sum;
    logic signed [63:0]   acc_dif;
    logic signed [63:0]   prod_q;
    logic signed [63:0]   accq_sum;
    logic signed [63:0]   accq_dif;
    logic                 accept;

    taq_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (cor_ctrl),
        .i_x     (cor_x_in),
        .i_y     (cor_y_in),
        .i_z     (cor_z_in),
        .o_stat  (cor_stat),
        .o_x     (cor_x),
        .o_y     (cor_y),
        .o_z     (cor_z)
    );

    assign accept = start && !busy;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (start) n_state = S_YAW_GO;
            S_YAW_GO:    n_state = S_YAW_RUN;
            S_YAW_RUN:   if (cor_stat.done) n_state = S_ROT_MUL;
            S_ROT_MUL:   if (r_step == ROT_MUL_LAST) n_state = S_ROLL_GO;
            S_ROLL_GO:   n_state = S_ROLL_RUN;
            S_ROLL_RUN:  if (cor_stat.done) n_state = S_HYP_MUL;
            S_HYP_MUL:   if (r_step == HYP_MUL_LAST) n_state = S_PITCH_GO;
            S_PITCH_GO:  n_state = S_PITCH_RUN;
            S_PITCH_RUN: if (cor_stat.done) n_state = S_HR_GO;
            S_HR_GO:     n_state = S_HR_RUN;
            S_HR_RUN:    if (cor_stat.done) n_state = S_HP_GO;
            S_HP_GO:     n_state = S_HP_RUN;
            S_HP_RUN:    if (cor_stat.done) n_state = S_HY_GO;
            S_HY_GO:     n_state = S_HY_RUN;
            S_HY_RUN:    if (cor_stat.done) n_state = S_QUAT_MUL;
            S_QUAT_MUL:  if (r_step == QUAT_MUL_LAST) n_state = S_DONE;
            S_DONE:      n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // outputs: handshake, CORDIC operands, multiplier operands
    always_comb begin
        busy     = (r_state != S_IDLE);
        o_strobe = (r_state == S_DONE);
        cor_ctrl = '0;
        cor_x_in = '0;
        cor_y_in = '0;
        cor_z_in = '0;
        mul_a    = '0;
        mul_b    = '0;
        case (r_state)
            S_YAW_GO: begin
                cor_ctrl.start = 1'b1;
                cor_z_in       = AW'(r_yaw) <<< 17;
            end
            S_ROT_MUL: begin
                case (r_step)
                    4'd0: begin mul_a = MW_A'(r_tx); mul_b = r_cos; end
                    4'd1: begin mul_a = MW_A'(r_ty); mul_b = r_sin; end
                    4'd2: begin mul_a = MW_A'(r_tx); mul_b = r_sin; end
                    4'd3: begin mul_a = MW_A'(r_ty); mul_b = r_cos; end
                    default: ;
                endcase
            end
            S_ROLL_GO: begin
                cor_ctrl.start = 1'b1;
                cor_ctrl.vec   = 1'b1;
                cor_x_in       = DW'(r_tz) <<< 16;
                cor_y_in       = DW'(r_ry) <<< 16;
            end
            S_HYP_MUL: begin
                if (r_step == '0) begin
                    mul_a = MW_A'(r_vmag >>> 16);
                    mul_b = INV_GAIN;
                end
            end
            S_PITCH_GO: begin
                cor_ctrl.start = 1'b1;
                cor_ctrl.vec   = 1'b1;
                cor_x_in       = r_vmag;
                cor_y_in       = DW'(r_rx) <<< 16;
            end
            S_HR_GO: begin
                cor_ctrl.start = 1'b1;
                cor_z_in       = r_roll >>> 1;
            end
            S_HP_GO: begin
                cor_ctrl.start = 1'b1;
                cor_z_in       = r_pitch >>> 1;
            end
            S_HY_GO: begin
                cor_ctrl.start = 1'b1;
                cor_z_in       = AW'(r_yaw) <<< 16;
            end
            S_QUAT_MUL: begin
                case (r_step)
                    4'd0:  begin mul_a = MW_A'(r_cr);   mul_b = r_cp;  end
                    4'd1:  begin mul_a = MW_A'(r_sr);   mul_b = r_sp;  end
                    4'd2:  begin mul_a = MW_A'(r_cr);   mul_b = r_sp;  end
                    4'd3:  begin mul_a = MW_A'(r_sr);   mul_b = r_cp;  end
                    4'd4:  begin mul_a = MW_A'(r_crcp); mul_b = r_cos; end
                    4'd5:  begin mul_a = MW_A'(r_srsp); mul_b = r_sin; end
                    4'd6:  begin mul_a = MW_A'(r_srcp); mul_b = r_cos; end
                    4'd7:  begin mul_a = MW_A'(r_crsp); mul_b = r_sin; end
                    4'd8:  begin mul_a = MW_A'(r_crsp); mul_b = r_cos; end
                    4'd9:  begin mul_a = MW_A'(r_srcp); mul_b = r_sin; end
                    4'd10: begin mul_a = MW_A'(r_crcp); mul_b = r_sin; end
                    4'd11: begin mul_a = MW_A'(r_srsp); mul_b = r_cos; end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // multiplier and accumulate paths
    assign mul_p    = mul_a * mul_b;
    assign acc_sum  = r_acc + r_prod;
    assign acc_dif  = r_acc - r_prod;
    assign prod_q   = r_prod >>> 30;
    assign accq_sum = r_acc + prod_q;
    assign accq_dif = r_acc - prod_q;

    // sequencer, step counter and gravity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= '0;
            r_gravity <= GRAVITY_RST;
        end else begin
            r_state <= n_state;
            r_step  <= (n_state == r_state) ? r_step + 1'b1 : '0;
            if (i_cfg_we) begin
                r_gravity <= i_cfg_wdata;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p[63:0];

        // input capture, gravity added to vertical thrust
        if (accept) begin
            r_pos_x <= i_pos_x;
            r_pos_y <= i_pos_y;
            r_pos_z <= i_pos_z;
            r_yaw   <= i_yaw_angle;
            r_tx    <= i_accel_x;
            r_ty    <= i_accel_y;
            r_tz    <= 33'(i_accel_z) + 33'(r_gravity);
        end

        case (r_state)
            S_YAW_RUN: begin
                if (cor_stat.done) begin
                    r_cos <= TW'(cor_x);
                    r_sin <= TW'(cor_y);
                end
            end
            // horizontal thrust rotated by +yaw
            S_ROT_MUL: begin
                case (r_step)
                    4'd1: r_acc <= r_prod;
                    4'd2: r_rx  <= 33'(acc_dif >>> 30);
                    4'd3: r_acc <= r_prod;
                    4'd4: r_ry  <= 33'(acc_sum >>> 30);
                    default: ;
                endcase
            end
            S_ROLL_RUN: begin
                if (cor_stat.done) begin
                    r_roll <= cor_z;
                    r_vmag <= cor_x;
                end
            end
            // gain-corrected hypot for the pitch vector
            S_HYP_MUL: begin
                if (r_step == HYP_MUL_LAST) begin
                    r_vmag <= DW'(r_prod >>> 14);
                end
            end
            S_PITCH_RUN: begin
                if (cor_stat.done) begin
                    r_pitch <= cor_z;
                end
            end
            S_HR_RUN: begin
                if (cor_stat.done) begin
                    r_cr <= TW'(cor_x);
                    r_sr <= TW'(cor_y);
                end
            end
            S_HP_RUN: begin
                if (cor_stat.done) begin
                    r_cp <= TW'(cor_x);
                    r_sp <= TW'(cor_y);
                end
            end
            S_HY_RUN: begin
                if (cor_stat.done) begin
                    r_cos <= TW'(cor_x);
                    r_sin <= TW'(cor_y);
                end
            end
            // pair products, then the four quaternion terms
            S_QUAT_MUL: begin
                case (r_step)
                    4'd1:  r_crcp <= TW'(prod_q);
                    4'd2:  r_srsp <= TW'(prod_q);
                    4'd3:  r_crsp <= TW'(prod_q);
                    4'd4:  r_srcp <= TW'(prod_q);
                    4'd5:  r_acc  <= prod_q;
                    4'd6:  r_qw   <= to_q14(34'(accq_sum));
                    4'd7:  r_acc  <= prod_q;
                    4'd8:  r_qx   <= to_q14(34'(accq_dif));
                    4'd9:  r_acc  <= prod_q;
                    4'd10: r_qy   <= to_q14(34'(accq_sum));
                    4'd11: r_acc  <= prod_q;
                    4'd12: r_qz   <= to_q14(34'(accq_dif));
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    assign o_out_x  = r_pos_x;
    assign o_out_y  = r_pos_y;
    assign o_out_z  = r_pos_z;
    assign o_quat_w = r_qw;
    assign o_quat_x = r_qx;
    assign o_quat_y = r_qy;
    assign o_quat_z = r_qz;

    // checks
    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (busy && !o_strobe))
        else $error("accepted transaction did not raise busy");

    a_cordic_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cor_ctrl.start |-> !cor_stat.busy)
        else $error("CORDIC started while running");

    a_cordic_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cor_stat.done |-> $past(cor_stat.busy))
        else $error("CORDIC done without a pass");

endmodule

`default_nettype wire
